// ===== sv/stp_pkg.sv =====
// shared types, constants and the speed profile table for the stepper ramp generator
// no dependencies; used by stp_core and stepper_trapezoid_profile
package stp_pkg;

    localparam int MICROSTEP_DIVIDER_DEF = 8;
    localparam int PROFILE_LENGTH_DEF    = 12;

    localparam int COUNT_W  = 16;
    localparam int STEPS_W  = 24;
    localparam int RAMP_W   = 4;
    localparam int PERIOD_W = 18;
    localparam int POS_W    = 32;

    localparam logic [PERIOD_W-1:0] START_PERIOD = PERIOD_W'(10000);
    localparam logic [PERIOD_W-1:0] STOP_PERIOD  = '0;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ACCEL,
        PH_CRUISE,
        PH_DECEL
    } phase_t;

    typedef struct packed {
        phase_t                   phase;
        logic [STEPS_W-1:0]       phase_index;
        logic [RAMP_W-1:0]        accel_steps;
        logic [STEPS_W-1:0]       cruise_steps;
        logic [RAMP_W-1:0]        decel_steps;
        logic                     direction_step;
        logic signed [POS_W-1:0]  position_count;
    } move_state_t;

    typedef struct packed {
        logic                     busy_res;
        logic signed [POS_W-1:0]  position;
        logic                     dir_level;
        logic [PERIOD_W-1:0]      period_us;
        logic                     timer_write;
        logic                     step_pulse;
    } step_result_t;

    // speed profile, slowest first; entries past the end repeat the fastest
    function automatic logic [PERIOD_W-1:0] speed_at(input logic [RAMP_W-1:0] idx);
        logic [PERIOD_W-1:0] val;
        case (idx)
            4'd0:    val = PERIOD_W'(189437);
            4'd1:    val = PERIOD_W'(52865);
            4'd2:    val = PERIOD_W'(38820);
            4'd3:    val = PERIOD_W'(32249);
            4'd4:    val = PERIOD_W'(28390);
            4'd5:    val = PERIOD_W'(25868);
            4'd6:    val = PERIOD_W'(24127);
            4'd7:    val = PERIOD_W'(22289);
            4'd8:    val = PERIOD_W'(22021);
            4'd9:    val = PERIOD_W'(21421);
            4'd10:   val = PERIOD_W'(21045);
            default: val = PERIOD_W'(20863);
        endcase
        return val;
    endfunction

endpackage

// ===== sv/stepper_trapezoid_profile.sv =====
// stepper ramp generator: an accepted input word yields its output word in the next cycle
// one word per cycle unless output stalls; state update and table lookup are combinational
// input is taken whenever the output register is empty or being drained
// reset (rst_n low, asynchronous) returns to idle at position 0, counterclockwise
// depends on stp_pkg and stp_core
module stepper_trapezoid_profile #(
    parameter int MICROSTEP_DIVIDER = stp_pkg::MICROSTEP_DIVIDER_DEF,
    parameter int PROFILE_LENGTH    = stp_pkg::PROFILE_LENGTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // step_count[15:0], clockwise[16], zero[23:17]
    input  logic [0:0]  s_tuser,   // action[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // step_pulse[0], timer_write[1], period_us[19:2],
                                   // dir_level[20], position[52:21], busy_res[53], zero[55:54]
);

    stp_pkg::move_state_t  state_reg;
    stp_pkg::move_state_t  state_next;
    stp_pkg::step_result_t res_reg;
    stp_pkg::step_result_t res_next;
    logic                  out_valid_reg;
    logic                  take;

    assign s_tready = !out_valid_reg || m_tready;
    assign take     = s_tvalid && s_tready;

    stp_core #(
        .MICROSTEP_DIVIDER (MICROSTEP_DIVIDER),
        .PROFILE_LENGTH    (PROFILE_LENGTH)
    ) u_core (
        .action     (s_tuser[0]),
        .step_count (s_tdata[15:0]),
        .clockwise  (s_tdata[16]),
        .cur        (state_reg),
        .nxt        (state_next),
        .res        (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (take)
            res_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, res_reg};

endmodule

// ===== sv/stp_core.sv =====
// next-state and result logic for one word of the stepper ramp generator
// depends on stp_pkg; purely combinational, state is held by the top level
module stp_core #(
    parameter int MICROSTEP_DIVIDER = stp_pkg::MICROSTEP_DIVIDER_DEF,
    parameter int PROFILE_LENGTH    = stp_pkg::PROFILE_LENGTH_DEF
) (
    input  logic                         action,
    input  logic [stp_pkg::COUNT_W-1:0]  step_count,
    input  logic                         clockwise,
    input  stp_pkg::move_state_t         cur,
    output stp_pkg::move_state_t         nxt,
    output stp_pkg::step_result_t        res
);

    localparam int TWICE_LEN = 2 * PROFILE_LENGTH;

    logic [stp_pkg::STEPS_W-1:0]  total;
    logic [stp_pkg::RAMP_W-1:0]   half_total;
    logic [stp_pkg::RAMP_W-1:0]   decel_idx;
    stp_pkg::phase_t              ph;
    logic [stp_pkg::STEPS_W-1:0]  idx;
    logic                         pulse;
    logic                         twrite;
    logic [stp_pkg::PERIOD_W-1:0] period;

    // scaled count fits in 24 bits for any divider up to 256
    assign total      = stp_pkg::STEPS_W'(32'(step_count) * MICROSTEP_DIVIDER);
    assign half_total = stp_pkg::RAMP_W'(total >> 1);

    always_comb
    begin
        nxt       = cur;
        pulse     = 1'b0;
        twrite    = 1'b0;
        period    = stp_pkg::STOP_PERIOD;
        ph        = cur.phase;
        idx       = cur.phase_index;
        decel_idx = '0;

        if (action)
        begin
            if (total != '0 && cur.phase == stp_pkg::PH_IDLE)
            begin
                if (total < stp_pkg::STEPS_W'(TWICE_LEN))
                begin
                    nxt.accel_steps  = half_total;
                    nxt.decel_steps  = stp_pkg::RAMP_W'(total) - half_total;
                    nxt.cruise_steps = '0;
                end
                else
                begin
                    nxt.accel_steps  = stp_pkg::RAMP_W'(PROFILE_LENGTH);
                    nxt.decel_steps  = stp_pkg::RAMP_W'(PROFILE_LENGTH);
                    nxt.cruise_steps = total - stp_pkg::STEPS_W'(TWICE_LEN);
                end
                nxt.direction_step = clockwise;
                nxt.phase          = stp_pkg::PH_ACCEL;
                nxt.phase_index    = '0;
                twrite             = 1'b1;
                period             = stp_pkg::START_PERIOD;
            end
        end
        else if (cur.phase != stp_pkg::PH_IDLE)
        begin
            // empty phases fall through within the same word
            if (ph == stp_pkg::PH_ACCEL)
            begin
                if (idx >= stp_pkg::STEPS_W'(cur.accel_steps))
                begin
                    idx = '0;
                    ph  = stp_pkg::PH_CRUISE;
                end
                else
                begin
                    twrite = 1'b1;
                    period = stp_pkg::speed_at(idx[stp_pkg::RAMP_W-1:0]);
                    pulse  = 1'b1;
                end
            end
            if (ph == stp_pkg::PH_CRUISE)
            begin
                if (idx >= cur.cruise_steps)
                begin
                    idx = '0;
                    ph  = stp_pkg::PH_DECEL;
                end
                else
                begin
                    twrite = 1'b1;
                    period = stp_pkg::speed_at(stp_pkg::RAMP_W'(PROFILE_LENGTH - 1));
                    pulse  = 1'b1;
                end
            end
            if (ph == stp_pkg::PH_DECEL)
            begin
                if (idx >= stp_pkg::STEPS_W'(cur.decel_steps))
                begin
                    twrite = 1'b1;
                    period = stp_pkg::STOP_PERIOD;
                    idx    = '0;
                    ph     = stp_pkg::PH_IDLE;
                end
                else
                begin
                    // profile read backward
                    decel_idx = cur.decel_steps - stp_pkg::RAMP_W'(1)
                              - idx[stp_pkg::RAMP_W-1:0];
                    twrite    = 1'b1;
                    period    = stp_pkg::speed_at(decel_idx);
                    pulse     = 1'b1;
                end
            end

            nxt.phase       = ph;
            nxt.phase_index = pulse ? idx + stp_pkg::STEPS_W'(1) : idx;
            if (pulse)
            begin
                if (cur.direction_step)
                    nxt.position_count = cur.position_count - stp_pkg::POS_W'(1);
                else
                    nxt.position_count = cur.position_count + stp_pkg::POS_W'(1);
            end
        end

        res.step_pulse  = pulse;
        res.timer_write = twrite;
        res.period_us   = period;
        res.dir_level   = nxt.direction_step;
        res.position    = nxt.position_count;
        res.busy_res    = (nxt.phase != stp_pkg::PH_IDLE);
    end

endmodule
